[sv/kskr_pkg.sv]
// Shared constants and controller/datapath types for the keyboard key-map reporter.
`default_nettype none

package kskr_pkg;

   // Field widths
   localparam int BYTE_W  = 8;
   localparam int GAP_W   = 16;
   localparam int CSUM_W  = 16;
   localparam int BITS_W  = 3;

   // Default number of key-map bytes (128 keys)
   localparam int MAP_BYTES_DEF = 16;

   // Register reset value and special codes
   localparam logic [GAP_W-1:0]  GAP_TIMEOUT_RST = 16'd100;
   localparam logic [BYTE_W-1:0] NEWLINE_CODE    = 8'h0A;
   localparam logic [BYTE_W-1:0] IGNORED_CODE    = 8'hFF;

   // Request opcodes
   localparam logic OP_EDGE   = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;        // request transaction taken this cycle
      logic begin_frame;   // rewind frame counter and checksum
      logic emit;          // load the next frame byte into the output register
   } kskr_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic frame_req;     // current request produces a frame
      logic out_free;      // output register can take a byte this cycle
      logic frame_end;     // next byte to load is the closing newline
   } kskr_sts_type;

endpackage

`default_nettype wire

[sv/kskr_req_if.sv]
// Request channel interface: keyboard edges and report requests.
`default_nettype none

interface kskr_req_if import kskr_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             opcode;
   logic             data_bit;
   logic [GAP_W-1:0] gap_us;

   modport source (output valid, opcode, data_bit, gap_us, input ready);
   modport sink   (input valid, opcode, data_bit, gap_us, output ready);
endinterface

`default_nettype wire

[sv/kskr_rsp_if.sv]
// Response channel interface: report frame bytes.
`default_nettype none

interface kskr_rsp_if import kskr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last_byte;

   modport source (output valid, out_byte, last_byte, input ready);
   modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

`default_nettype wire

[sv/keyboard_serial_keymap_reporter.sv]
// Top level of the keyboard serial key-map reporter.
`default_nettype none

// Receives a keyboard's serial scan codes one bit per edge request transaction,
// keeps a 128-key down map and sends a 37-byte report frame (two nibble
// bytes per map byte, four checksum nibble bytes, newline) after each
// completed code other than 0xFF and after each report request. A request
// that produces neither leaves the block ready; one that produces a frame
// holds off further requests while the frame byte counter feeds the frame
// bytes into the output register; stalls on the response side stretch
// this. The next request is taken while the closing byte still waits in
// the output register. The gap timeout register is written through csr_wr_en.

module keyboard_serial_keymap_reporter import kskr_pkg::*; #(
   parameter int MAP_BYTES = MAP_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [GAP_W-1:0] csr_wr_data,
   kskr_req_if.sink         req_chan,
   kskr_rsp_if.source       rsp_chan
);

   kskr_cmd_type cmd;
   kskr_sts_type sts;

   // Controller
   kskr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath
   kskr_dp #(
      .MAP_BYTES (MAP_BYTES)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_opcode    (req_chan.opcode),
      .req_data_bit  (req_chan.data_bit),
      .req_gap_us    (req_chan.gap_us),
      .rsp_ready     (rsp_chan.ready),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_valid     (rsp_chan.valid),
      .rsp_out_byte  (rsp_chan.out_byte),
      .rsp_last_byte (rsp_chan.last_byte)
   );

   // A report request always starts a frame, so the block is busy next cycle
   a_report_busy: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.opcode == OP_REPORT)
      |=> !req_chan.ready)
      else $error("report request did not start a frame");

   // The closing byte of a frame is the newline
   a_last_newline: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.last_byte) |-> (rsp_chan.out_byte == NEWLINE_CODE))
      else $error("frame closed with a byte other than newline");

   // Two closing bytes never follow each other
   a_no_double_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.last_byte)
      |=> !(rsp_chan.valid && rsp_chan.last_byte))
      else $error("closing byte repeated");

endmodule

`default_nettype wire

[sv/kskr_ctrl.sv]
// Controller: accepts requests and sequences frame emission.
`default_nettype none

module kskr_ctrl import kskr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  kskr_sts_type sts,
   output kskr_cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   state_type state_ff;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Command decode
   always_comb begin
      cmd.accept      = accept;
      cmd.begin_frame = accept && sts.frame_req;
      cmd.emit        = (state_ff == ST_EMIT) && sts.out_free;
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && sts.frame_req) state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (sts.out_free && sts.frame_end) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

[sv/kskr_dp.sv]
// Datapath: bit assembly, key map, frame byte generation and output register.
`default_nettype none

module kskr_dp import kskr_pkg::*; #(
   parameter int MAP_BYTES = MAP_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [GAP_W-1:0]  csr_wr_data,
   input  logic              req_opcode,
   input  logic              req_data_bit,
   input  logic [GAP_W-1:0]  req_gap_us,
   input  logic              rsp_ready,
   input  kskr_cmd_type      cmd,
   output kskr_sts_type      sts,
   output logic              rsp_valid,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_last_byte
);

   localparam int MAP_IDX_W = $clog2(MAP_BYTES);
   localparam int MAP_SPAN  = 2 * MAP_BYTES;
   localparam int FRAME_LEN = MAP_SPAN + 5;
   localparam int CNT_W     = $clog2(FRAME_LEN);

   // Positions in the frame tail
   localparam logic [2:0] TAIL_SUM0 = 3'd0;
   localparam logic [2:0] TAIL_SUM1 = 3'd1;
   localparam logic [2:0] TAIL_SUM2 = 3'd2;
   localparam logic [2:0] TAIL_SUM3 = 3'd3;
   localparam logic [2:0] TAIL_NL   = 3'd4;

   logic [GAP_W-1:0]  timeout_ff;
   logic [BITS_W-1:0] bit_count_ff;
   logic [BYTE_W-1:0] shift_ff;
   logic [BYTE_W-1:0] map_ff [MAP_BYTES];
   logic [CNT_W-1:0]  cnt_ff;
   logic [CSUM_W-1:0] sum_ff;
   logic              valid_ff;
   logic [BYTE_W-1:0] out_ff;
   logic              last_ff;

   logic [BITS_W-1:0]    base_cnt;
   logic [BYTE_W-1:0]    base_byte;
   logic [BYTE_W-1:0]    shifted;
   logic [BYTE_W-1:0]    code;
   logic                 byte_done;
   logic                 code_ok;
   logic                 take_edge;
   logic [MAP_IDX_W-1:0] key_sel;
   logic [2:0]           key_bit;

   logic                 in_map;
   logic [BYTE_W-1:0]    map_byte;
   logic [CNT_W-1:0]     tail_off;
   logic [2:0]           tail_pos;
   logic [BYTE_W-1:0]    byte_in;

   // Bit assembly: a long gap drops any partial byte
   always_comb begin
      if (req_gap_us > timeout_ff) begin
         base_cnt  = '0;
         base_byte = '0;
      end else begin
         base_cnt  = bit_count_ff;
         base_byte = shift_ff;
      end
      byte_done = (base_cnt == 3'd7);
      if (byte_done) shifted = base_byte | {req_data_bit, 7'b0};
      else           shifted = base_byte | (BYTE_W'(req_data_bit) << (3'd6 - base_cnt));
      code    = ~shifted;
      code_ok = byte_done && (code != IGNORED_CODE);
   end

   assign take_edge = cmd.accept && (req_opcode == OP_EDGE);
   assign key_sel   = MAP_IDX_W'(code[6:3]);
   assign key_bit   = code[2:0];

   // Frame byte selection
   assign in_map   = (cnt_ff < CNT_W'(MAP_SPAN));
   assign map_byte = map_ff[cnt_ff[MAP_IDX_W:1]];
   assign tail_off = cnt_ff - CNT_W'(MAP_SPAN);
   assign tail_pos = tail_off[2:0];

   always_comb begin
      if (in_map) begin
         if (cnt_ff[0]) byte_in = {map_byte[7:4], 4'h0};
         else           byte_in = {map_byte[3:0], 4'h0};
      end else begin
         case (tail_pos)
            TAIL_SUM0: byte_in = {sum_ff[3:0], 4'h0};
            TAIL_SUM1: byte_in = {sum_ff[7:4], 4'h0};
            TAIL_SUM2: byte_in = {sum_ff[11:8], 4'h0};
            TAIL_SUM3: byte_in = {sum_ff[15:12], 4'h0};
            default:   byte_in = NEWLINE_CODE;
         endcase
      end
   end

   // Status to the controller
   always_comb begin
      sts.frame_req = (req_opcode == OP_REPORT) || code_ok;
      sts.out_free  = !valid_ff || rsp_ready;
      sts.frame_end = (cnt_ff == CNT_W'(FRAME_LEN - 1));
   end

   // Register, bit assembly and key map
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= GAP_TIMEOUT_RST;
         bit_count_ff <= '0;
         shift_ff     <= '0;
         for (int i = 0; i < MAP_BYTES; i++) map_ff[i] <= '0;
      end else begin
         if (csr_wr_en) timeout_ff <= csr_wr_data;
         if (take_edge) begin
            if (byte_done) begin
               bit_count_ff <= '0;
               shift_ff     <= '0;
               if (code_ok) map_ff[key_sel][key_bit] <= !code[7];
            end else begin
               bit_count_ff <= base_cnt + 3'd1;
               shift_ff     <= shifted;
            end
         end
      end
   end

   // Frame counter and running checksum
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sum_ff <= '0;
      end else if (cmd.begin_frame) begin
         cnt_ff <= '0;
         sum_ff <= '0;
      end else if (cmd.emit) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (in_map && cnt_ff[0]) sum_ff <= sum_ff + CSUM_W'(map_byte);
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_ff  <= byte_in;
         last_ff <= !in_map && (tail_pos == TAIL_NL);
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = out_ff;
   assign rsp_last_byte = last_ff;

endmodule

`default_nettype wire
